// ===== design/rmeu_pkg.sv =====
// ----------------------------------------------------------------------------
// rmeu_pkg: shared types and constants of the register machine execute unit
// Operation codes, operation classes, the decoded item carried from the
// front end to the back end, and the result item layout.
// ----------------------------------------------------------------------------
package rmeu_pkg;

    localparam int XLEN        = 32;
    localparam int RIDX_W      = 5;
    localparam int NREGS       = 32;
    localparam int MEM_BYTES   = 65536;
    localparam int MEM_AW      = $clog2(MEM_BYTES);
    localparam int INSTR_BYTES = 4;
    localparam int QDEPTH      = 2;
    localparam int Q_AW        = $clog2(QDEPTH);
    localparam int Q_CW        = $clog2(QDEPTH + 1);
    localparam int DIV_STEPS   = XLEN;
    localparam int DIV_CW      = $clog2(DIV_STEPS);
    localparam int KIND_W      = 6;
    localparam int S_TDATA_W   = 104;
    localparam int M_TDATA_W   = 200;

    localparam logic [RIDX_W-1:0] LINK_REG     = 5'd31;
    localparam logic [RIDX_W-1:0] SYS_CODE_REG = 5'd2;
    localparam logic [RIDX_W-1:0] SYS_ARG_REG  = 5'd4;

    // operation codes, numbered densely from zero
    typedef enum logic [KIND_W-1:0] {
        K_ADD, K_ADDU, K_ADDIU, K_SUB, K_SUBU, K_XOR, K_XORU, K_REM, K_REMU,
        K_SEQ, K_SGE, K_SGT, K_SLE, K_SLT, K_SNE, K_NEG, K_NEGU, K_LI, K_MOVE,
        K_MFHI, K_MFLO, K_JR, K_JALR, K_MUL, K_MULU, K_DIV, K_DIVU, K_B, K_J,
        K_JAL, K_BEQ, K_BNE, K_BGE, K_BLE, K_BGT, K_BLT, K_BEQZ, K_BNEZ,
        K_BLEZ, K_BGEZ, K_BGTZ, K_BLTZ, K_LA, K_LB, K_LH, K_LW, K_SB, K_SH,
        K_SW, K_NOP, K_SYSCALL
    } kind_t;

    // which back-end path carries the item out
    typedef enum logic [3:0] {
        CL_NOP, CL_ALU, CL_MUL, CL_DIV, CL_JUMP, CL_BRANCH, CL_LOAD,
        CL_STORE, CL_SYS
    } op_class_t;

    typedef struct packed {
        kind_t             kind;
        op_class_t         cls;
        logic [RIDX_W-1:0] rd;
        logic [RIDX_W-1:0] idx_a;
        logic [RIDX_W-1:0] idx_b;
        logic              d_abs;
        logic              s1_abs;
        logic              s2_abs;
        logic              hilo;
        logic [XLEN-1:0]   imm;
        logic [XLEN-1:0]   disp;
        logic [XLEN-1:0]   tgt;
    } dec_t;

    typedef struct packed {
        logic [XLEN-1:0]   syscall_arg;
        logic [XLEN-1:0]   syscall_code;
        logic              syscall_request;
        logic [XLEN-1:0]   lo_value;
        logic [XLEN-1:0]   hi_value;
        logic              hilo_written;
        logic [XLEN-1:0]   reg_value;
        logic [RIDX_W-1:0] reg_index;
        logic              reg_written;
        logic [XLEN-1:0]   next_pc;
    } res_t;

endpackage

// ===== design/register_machine_execute_unit_top.sv =====
// ALU, jump and branch items get their result in the sequencer's read step; multiply
// adds a registered product step; divide and remainder wait on the divider (one
// quotient bit a cycle); loads and stores go through memory one byte at a time.
// The back end works on one item at a time; a 2-entry queue takes new items meanwhile.
// Reset: synchronous active-low; data memory is cleared after reset, with s_tready
// low until the clearing pass ends.
// ----------------------------------------------------------------------------
// register_machine_execute_unit_top: integer execute unit of a register machine
// Front end decodes and queues instruction transactions; back end executes
// them against the register file, HI/LO and byte memory.
// ----------------------------------------------------------------------------
module register_machine_execute_unit_top import rmeu_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [XLEN-1:0]      cfg_wr_data,   // start_address
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [KIND_W-1:0]    s_tuser,       // kind
    // dest_reg[4:0], src1_reg[9:5], src2_reg[14:10], dest_absent[15],
    // src1_absent[16], src2_absent[17], hilo_form[18], immediate[50:19],
    // displacement[66:51], target[98:67], zero[103:99]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // next_pc[31:0], reg_written[32], reg_index[37:33], reg_value[69:38],
    // hilo_written[70], hi_value[102:71], lo_value[134:103],
    // syscall_request[135], syscall_code[167:136], syscall_arg[199:168]
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic accept_en;
    logic q_valid;
    logic q_pop;
    dec_t q_item;
    res_t m_res;

    rmeu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept_en (accept_en),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .q_pop     (q_pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    rmeu_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept_en   (accept_en),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_res       (m_res)
    );

    // struct layout matches the tdata field order
    assign m_tdata = m_res;

endmodule

// ===== design/rmeu_front.sv =====
// ----------------------------------------------------------------------------
// rmeu_front: input side of the execute unit
// Accepts instruction transactions, classifies them, picks register read
// indices and queues the decoded item for the back end.
// ----------------------------------------------------------------------------
module rmeu_front import rmeu_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept_en,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [KIND_W-1:0]    s_tuser,   // kind
    // dest_reg, src1_reg, src2_reg, dest_absent, src1_absent, src2_absent,
    // hilo_form, immediate, displacement, target, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 q_pop,
    output logic                 q_valid,
    output dec_t                 q_item
);

    dec_t            dec;
    dec_t            q_mem_reg [QDEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_CW-1:0] count_reg;
    logic            push;
    logic            md_op;

    // field unpack and classification
    always_comb begin
        dec        = '0;
        dec.rd     = s_tdata[4:0];
        dec.d_abs  = s_tdata[15];
        dec.s1_abs = s_tdata[16];
        dec.s2_abs = s_tdata[17];
        dec.imm    = s_tdata[50:19];
        dec.disp   = {{16{s_tdata[66]}}, s_tdata[66:51]};
        dec.tgt    = s_tdata[98:67];
        if (s_tuser > KIND_W'(K_SYSCALL)) begin
            dec.kind = K_NOP;
        end else begin
            dec.kind = kind_t'(s_tuser);
        end
        unique case (dec.kind)
            K_REM, K_REMU, K_DIV, K_DIVU:         dec.cls = CL_DIV;
            K_MUL, K_MULU:                        dec.cls = CL_MUL;
            K_JR, K_JALR, K_B, K_J, K_JAL:        dec.cls = CL_JUMP;
            K_BEQ, K_BNE, K_BGE, K_BLE, K_BGT, K_BLT, K_BEQZ, K_BNEZ,
            K_BLEZ, K_BGEZ, K_BGTZ, K_BLTZ:       dec.cls = CL_BRANCH;
            K_LB, K_LH, K_LW:                     dec.cls = CL_LOAD;
            K_SB, K_SH, K_SW:                     dec.cls = CL_STORE;
            K_NOP:                                dec.cls = CL_NOP;
            K_SYSCALL:                            dec.cls = CL_SYS;
            default:                              dec.cls = CL_ALU;
        endcase
        // two-operand multiply/divide only for the four HI/LO capable codes
        md_op    = (dec.kind == K_MUL) || (dec.kind == K_MULU) ||
                   (dec.kind == K_DIV) || (dec.kind == K_DIVU);
        dec.hilo = md_op && s_tdata[18];
        // read ports: A = src1 or r2, B = src2, dest or r4
        if (dec.cls == CL_SYS) begin
            dec.idx_a = SYS_CODE_REG;
            dec.idx_b = SYS_ARG_REG;
        end else begin
            dec.idx_a = s_tdata[9:5];
            if (dec.hilo || dec.cls == CL_STORE) begin
                dec.idx_b = s_tdata[4:0];
            end else begin
                dec.idx_b = s_tdata[14:10];
            end
        end
    end

    assign s_tready = accept_en && (count_reg != Q_CW'(QDEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = q_mem_reg[rd_ptr_reg];

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= dec;
        end
    end

    // queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !q_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (q_pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/rmeu_div.sv =====
// ----------------------------------------------------------------------------
// rmeu_div: iterative 32-bit divider
// Restoring division on magnitudes, one quotient bit per cycle, followed by
// a sign fix step. Division by zero yields all ones and the dividend.
// ----------------------------------------------------------------------------
module rmeu_div import rmeu_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic            sgn,
    input  logic [XLEN-1:0] dividend,
    input  logic [XLEN-1:0] divisor,
    output logic            done,
    output logic [XLEN-1:0] quotient,
    output logic [XLEN-1:0] remainder
);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} dstate_t;

    dstate_t           state_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [XLEN:0]     rem_reg;
    logic [XLEN-1:0]   dvd_reg;
    logic [XLEN-1:0]   dvs_reg;
    logic [XLEN-1:0]   orig_reg;
    logic              neg_q_reg;
    logic              neg_r_reg;
    logic              zero_reg;
    logic              done_reg;
    logic [XLEN-1:0]   q_reg;
    logic [XLEN-1:0]   r_reg;
    logic [XLEN:0]     rem_sh;
    logic [XLEN:0]     rem_sub;
    logic              qbit;

    // one restoring step
    always_comb begin
        rem_sh  = {rem_reg[XLEN-1:0], dvd_reg[XLEN-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        qbit    = (rem_sh >= {1'b0, dvs_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            // done pulses for the cycle after the fix step
            done_reg <= (state_reg == D_FIX);
            unique case (state_reg)
                D_IDLE: begin
                    if (start) begin
                        orig_reg  <= dividend;
                        zero_reg  <= (divisor == '0);
                        neg_q_reg <= sgn && (dividend[XLEN-1] ^ divisor[XLEN-1]);
                        neg_r_reg <= sgn && dividend[XLEN-1];
                        dvd_reg   <= (sgn && dividend[XLEN-1]) ? -dividend : dividend;
                        dvs_reg   <= (sgn && divisor[XLEN-1]) ? -divisor : divisor;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= D_RUN;
                    end
                end
                D_RUN: begin
                    rem_reg <= qbit ? rem_sub : rem_sh;
                    dvd_reg <= {dvd_reg[XLEN-2:0], qbit};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (&cnt_reg) begin
                        state_reg <= D_FIX;
                    end
                end
                D_FIX: begin
                    if (zero_reg) begin
                        q_reg <= '1;
                        r_reg <= orig_reg;
                    end else begin
                        q_reg <= neg_q_reg ? -dvd_reg : dvd_reg;
                        r_reg <= neg_r_reg ? -rem_reg[XLEN-1:0] : rem_reg[XLEN-1:0];
                    end
                    state_reg <= D_IDLE;
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

// ===== design/rmeu_back.sv =====
// ----------------------------------------------------------------------------
// rmeu_back: execution side of the execute unit
// Pops decoded items, reads the register file, runs ALU, multiply, divide,
// branch and byte-serial memory work, then commits state and registers the
// result transaction.
// ----------------------------------------------------------------------------
module rmeu_back import rmeu_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [XLEN-1:0] cfg_wr_data,
    output logic            accept_en,
    input  logic            q_valid,
    input  dec_t            q_item,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output res_t            m_res
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_MUL, S_DIV, S_MEMRD, S_MEMCAP, S_MEMWR, S_DONE
    } state_t;

    state_t            state_reg;
    logic [MEM_AW-1:0] clr_cnt_reg;
    dec_t              op_reg;
    logic [XLEN-1:0]   pc_reg;
    logic [XLEN-1:0]   hi_reg;
    logic [XLEN-1:0]   lo_reg;
    res_t              res_reg;
    res_t              out_reg;
    logic              out_valid_reg;
    logic [2*XLEN-1:0] prod_reg;
    logic [XLEN-1:0]   mem_addr_reg;
    logic [1:0]        mem_cnt_reg;
    logic [1:0]        mem_last_reg;
    logic [XLEN-1:0]   st_data_reg;
    logic [XLEN-1:0]   ld_reg;

    // register file and data memory
    logic [XLEN-1:0]   rf_mem [NREGS];
    logic [NREGS-1:0]  rf_valid_reg;
    logic [XLEN-1:0]   rda_reg;
    logic [XLEN-1:0]   rdb_reg;
    logic              rda_v_reg;
    logic              rdb_v_reg;
    logic [7:0]        dmem [MEM_BYTES];
    logic [7:0]        md_reg;

    logic [XLEN-1:0]   ra;
    logic [XLEN-1:0]   rb;
    logic [XLEN-1:0]   b;
    logic [XLEN-1:0]   hv;
    logic [XLEN-1:0]   seq;
    logic [XLEN-1:0]   alu_val;
    logic              take;
    logic              link;
    logic              wr_c;
    logic [XLEN-1:0]   npc_c;
    logic [XLEN-1:0]   m1;
    logic [XLEN-1:0]   m2;
    logic              msg;
    logic [2*XLEN+1:0] prod;
    logic              div_start;
    logic              div_sgn;
    logic              div_done;
    logic [XLEN-1:0]   div_q;
    logic [XLEN-1:0]   div_r;
    logic [XLEN-1:0]   byte_addr;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_wa;
    logic [7:0]        mem_wd;
    logic [XLEN-1:0]   ld_full;
    logic [XLEN-1:0]   ld_val;
    logic              out_free;
    logic              commit;

    // operands from the registered read data
    always_comb begin
        ra  = rda_v_reg ? rda_reg : '0;
        rb  = rdb_v_reg ? rdb_reg : '0;
        b   = op_reg.s2_abs ? op_reg.imm : rb;
        hv  = op_reg.s1_abs ? op_reg.imm : ra;
        seq = pc_reg + XLEN'(INSTR_BYTES);
    end

    // combinational results, branch decision and next pc
    always_comb begin
        alu_val = '0;
        take    = 1'b0;
        unique case (op_reg.kind)
            K_ADD, K_ADDU, K_ADDIU: alu_val = ra + b;
            K_SUB, K_SUBU:          alu_val = ra - b;
            K_XOR, K_XORU:          alu_val = ra ^ b;
            K_SEQ:   alu_val = XLEN'(ra == b);
            K_SGE:   alu_val = XLEN'(!($signed(ra) < $signed(b)));
            K_SGT:   alu_val = XLEN'($signed(b) < $signed(ra));
            K_SLE:   alu_val = XLEN'(!($signed(b) < $signed(ra)));
            K_SLT:   alu_val = XLEN'($signed(ra) < $signed(b));
            K_SNE:   alu_val = XLEN'(ra != b);
            K_NEG, K_NEGU: alu_val = -ra;
            K_LI:    alu_val = op_reg.imm;
            K_MOVE:  alu_val = ra;
            K_MFHI:  alu_val = hi_reg;
            K_MFLO:  alu_val = lo_reg;
            K_JALR, K_JAL: alu_val = seq;
            K_LA:    alu_val = op_reg.s1_abs ? op_reg.tgt : ra + op_reg.disp;
            K_BEQ:   take = (ra == b);
            K_BNE:   take = (ra != b);
            K_BGE:   take = !($signed(ra) < $signed(b));
            K_BLE:   take = !($signed(b) < $signed(ra));
            K_BGT:   take = $signed(b) < $signed(ra);
            K_BLT:   take = $signed(ra) < $signed(b);
            K_BEQZ:  take = (ra == '0);
            K_BNEZ:  take = (ra != '0);
            K_BLEZ:  take = !ra[XLEN-1] ? (ra == '0) : 1'b1;
            K_BGEZ:  take = !ra[XLEN-1];
            K_BGTZ:  take = !ra[XLEN-1] && (ra != '0);
            K_BLTZ:  take = ra[XLEN-1];
            default: alu_val = '0;
        endcase
        link = (op_reg.kind == K_JALR) || (op_reg.kind == K_JAL);
        wr_c = (op_reg.cls == CL_ALU) || link;
        if (op_reg.kind == K_JR || op_reg.kind == K_JALR) begin
            npc_c = ra;
        end else if (op_reg.kind == K_B || op_reg.kind == K_J ||
                     op_reg.kind == K_JAL || take) begin
            npc_c = op_reg.tgt;
        end else begin
            npc_c = seq;
        end
    end

    // multiplier, registered before use
    always_comb begin
        m1   = op_reg.hilo ? rb : ra;
        m2   = op_reg.hilo ? hv : b;
        msg  = (op_reg.kind == K_MUL);
        prod = $signed({msg & m1[XLEN-1], m1}) * $signed({msg & m2[XLEN-1], m2});
    end

    // divider
    assign div_start = (state_reg == S_READ) && (op_reg.cls == CL_DIV);
    assign div_sgn   = (op_reg.kind == K_DIV) || (op_reg.kind == K_REM);

    rmeu_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .sgn       (div_sgn),
        .dividend  (op_reg.hilo ? rb : ra),
        .divisor   (op_reg.hilo ? hv : b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // byte-serial memory address and load assembly
    always_comb begin
        byte_addr = mem_addr_reg + XLEN'(mem_cnt_reg);
        ld_full   = ld_reg | (XLEN'(md_reg) << {mem_cnt_reg, 3'b000});
        unique case (op_reg.kind)
            K_LB:    ld_val = {{24{ld_full[7]}}, ld_full[7:0]};
            K_LH:    ld_val = {{16{ld_full[15]}}, ld_full[15:0]};
            default: ld_val = ld_full;
        endcase
        mem_we = (state_reg == S_CLEAR) || (state_reg == S_MEMWR);
        mem_wa = (state_reg == S_CLEAR) ? clr_cnt_reg : byte_addr[MEM_AW-1:0];
        mem_wd = (state_reg == S_CLEAR) ? 8'h00 : st_data_reg[{mem_cnt_reg, 3'b000} +: 8];
    end

    assign out_free  = !out_valid_reg || m_tready;
    assign commit    = (state_reg == S_DONE) && out_free;
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign accept_en = (state_reg != S_CLEAR);

    // data memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            dmem[mem_wa] <= mem_wd;
        end
        md_reg <= dmem[byte_addr[MEM_AW-1:0]];
    end

    // register file storage and read ports
    always_ff @(posedge aclk) begin
        if (commit && res_reg.reg_written) begin
            rf_mem[res_reg.reg_index] <= res_reg.reg_value;
        end
        if (q_pop) begin
            rda_reg <= rf_mem[q_item.idx_a];
            rdb_reg <= rf_mem[q_item.idx_b];
        end
    end

    // register valid bits stand in for the zero reset of the file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_valid_reg <= '0;
        end else begin
            if (commit && res_reg.reg_written) begin
                rf_valid_reg[res_reg.reg_index] <= 1'b1;
            end
            if (q_pop) begin
                rda_v_reg <= rf_valid_reg[q_item.idx_a];
                rdb_v_reg <= rf_valid_reg[q_item.idx_b];
            end
        end
    end

    // sequencer, architectural state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            pc_reg        <= '0;
            hi_reg        <= '0;
            lo_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            // result register handshake
            if (commit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            // start address write also sets the fetch point
            if (cfg_wr_en) begin
                pc_reg <= cfg_wr_data;
            end else if (commit) begin
                pc_reg <= res_reg.next_pc;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (&clr_cnt_reg) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (q_valid) begin
                        op_reg    <= q_item;
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    res_reg.next_pc         <= npc_c;
                    res_reg.reg_written     <= wr_c;
                    res_reg.reg_index       <= !wr_c ? '0 : (link ? LINK_REG : op_reg.rd);
                    res_reg.reg_value       <= wr_c ? alu_val : '0;
                    res_reg.hilo_written    <= 1'b0;
                    res_reg.hi_value        <= '0;
                    res_reg.lo_value        <= '0;
                    res_reg.syscall_request <= (op_reg.cls == CL_SYS);
                    res_reg.syscall_code    <= (op_reg.cls == CL_SYS) ? ra : '0;
                    res_reg.syscall_arg     <= (op_reg.cls == CL_SYS) ? rb : '0;
                    prod_reg                <= prod[2*XLEN-1:0];
                    mem_addr_reg <= (op_reg.cls == CL_STORE)
                                  ? (op_reg.d_abs ? op_reg.tgt : rb + op_reg.disp)
                                  : (op_reg.s1_abs ? op_reg.tgt : ra + op_reg.disp);
                    mem_cnt_reg  <= '0;
                    ld_reg       <= '0;
                    st_data_reg  <= ra;
                    if (op_reg.kind == K_LB || op_reg.kind == K_SB) begin
                        mem_last_reg <= 2'd0;
                    end else if (op_reg.kind == K_LH || op_reg.kind == K_SH) begin
                        mem_last_reg <= 2'd1;
                    end else begin
                        mem_last_reg <= 2'd3;
                    end
                    unique case (op_reg.cls)
                        CL_MUL:   state_reg <= S_MUL;
                        CL_DIV:   state_reg <= S_DIV;
                        CL_LOAD:  state_reg <= S_MEMRD;
                        CL_STORE: state_reg <= S_MEMWR;
                        default:  state_reg <= S_DONE;
                    endcase
                end
                S_MUL: begin
                    if (op_reg.hilo) begin
                        res_reg.hilo_written <= 1'b1;
                        res_reg.hi_value     <= prod_reg[2*XLEN-1:XLEN];
                        res_reg.lo_value     <= prod_reg[XLEN-1:0];
                    end else begin
                        res_reg.reg_written <= 1'b1;
                        res_reg.reg_index   <= op_reg.rd;
                        res_reg.reg_value   <= prod_reg[XLEN-1:0];
                    end
                    state_reg <= S_DONE;
                end
                S_DIV: begin
                    if (div_done) begin
                        if (op_reg.hilo) begin
                            res_reg.hilo_written <= 1'b1;
                            res_reg.hi_value     <= div_r;
                            res_reg.lo_value     <= div_q;
                        end else begin
                            res_reg.reg_written <= 1'b1;
                            res_reg.reg_index   <= op_reg.rd;
                            res_reg.reg_value   <= (op_reg.kind == K_REM ||
                                                    op_reg.kind == K_REMU) ? div_r : div_q;
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_MEMRD: begin
                    state_reg <= S_MEMCAP;
                end
                S_MEMCAP: begin
                    ld_reg <= ld_full;
                    if (mem_cnt_reg == mem_last_reg) begin
                        res_reg.reg_written <= 1'b1;
                        res_reg.reg_index   <= op_reg.rd;
                        res_reg.reg_value   <= ld_val;
                        state_reg           <= S_DONE;
                    end else begin
                        mem_cnt_reg <= mem_cnt_reg + 1'b1;
                        state_reg   <= S_MEMRD;
                    end
                end
                S_MEMWR: begin
                    if (mem_cnt_reg == mem_last_reg) begin
                        state_reg <= S_DONE;
                    end else begin
                        mem_cnt_reg <= mem_cnt_reg + 1'b1;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        out_reg <= res_reg;
                        if (res_reg.hilo_written) begin
                            hi_reg <= res_reg.hi_value;
                            lo_reg <= res_reg.lo_value;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_res    = out_reg;

    // no result leaves while memory is being cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !out_valid_reg)
        else $error("result valid during memory clear");

    // a finished division always moves on to commit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV && div_done) |=> (state_reg == S_DONE))
        else $error("divide completion lost");

    // byte counter never runs past the access size
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MEMRD || state_reg == S_MEMWR) |-> (mem_cnt_reg <= mem_last_reg))
        else $error("memory byte counter overrun");

endmodule
